// File: design/pulse_width_sensor_frame_decoder_defines.svh
// Assertion macros shared by the frame decoder modules.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWSFD_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwsfd assertion failed");

// Next-cycle implication, checked outside reset.
`define PWSFD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwsfd assertion failed");

`endif

// File: design/pwsfd_pkg.sv
// Package for the pulse width sensor frame decoder: widths, limits,
// status codes and the frame handoff struct. No dependencies.
package pwsfd_pkg;

  localparam int DurW    = 15;
  localparam int CountW  = 8;
  localparam int PosW    = 8;
  localparam int FrameW  = 40;
  localparam int ByteW   = 8;
  localparam int TempW   = 12;
  localparam int HumW    = 7;
  localparam int TenthsW = 10;

  localparam logic [PosW-1:0]   MaxSymbols  = 8'd128;
  localparam logic [CountW-1:0] MinFrame    = 8'd41;
  localparam logic [PosW-1:0]   DataBits    = 8'd40;
  localparam logic [DurW-1:0]   ThreshReset = 15'd35;
  localparam logic [ByteW-1:0]  HumMax      = 8'd100;
  localparam logic [TempW-1:0]  TempMax     = 12'd600;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_t;

  // Completed capture handed from the bit stage to the check stage.
  typedef struct packed {
    logic [FrameW-1:0] bits;
    logic              short_frame;
  } frame_t;

endpackage

// File: design/pulse_width_sensor_frame_decoder.sv
// Single-wire sensor frame decoder: takes one captured pulse symbol per item
// on s_axis (one item per cycle sustained while m_axis is not stalled),
// slices it against bit_threshold and builds a 40-bit frame; the item
// carrying tlast closes the capture and yields one result item on m_axis
// through the symbol stage frame register and then the check register. Non-last
// items yield nothing. m_axis stalls back up through both, each one frame deep.
// Depends on pwsfd_pkg, pwsfd_bit_accum, pwsfd_frame_check.
module pulse_width_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,    // bit_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // duration_first[14:0], duration_second[29:15],
                                      // frame_symbols[37:30], zero pad[39:38]
  input  logic [0:0]  s_axis_tuser,   // level_first[0]
  input  logic        s_axis_tlast,   // last_symbol
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // humidity_percent[6:0], humidity_valid[7],
                                      // temperature_tenths[17:8], temperature_valid[18],
                                      // zero pad[23:19]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic                          frame_valid;
  logic                          frame_ready;
  pwsfd_pkg::frame_t             frame;
  pwsfd_pkg::status_t            status;
  logic [pwsfd_pkg::HumW-1:0]    humidity_percent;
  logic                          humidity_valid;
  logic [pwsfd_pkg::TenthsW-1:0] temperature_tenths;
  logic                          temperature_valid;

  pwsfd_bit_accum u_bit_accum (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .level_first     (s_axis_tuser[0]),
    .duration_first  (s_axis_tdata[14:0]),
    .duration_second (s_axis_tdata[29:15]),
    .frame_symbols   (s_axis_tdata[37:30]),
    .last_symbol     (s_axis_tlast),
    .frame_valid     (frame_valid),
    .frame_ready     (frame_ready),
    .frame           (frame)
  );

  pwsfd_frame_check u_frame_check (
    .clk                (clk),
    .rst                (rst),
    .frame_valid        (frame_valid),
    .frame_ready        (frame_ready),
    .frame              (frame),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .status             (status),
    .humidity_percent   (humidity_percent),
    .humidity_valid     (humidity_valid),
    .temperature_tenths (temperature_tenths),
    .temperature_valid  (temperature_valid)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {5'b00000, temperature_valid, temperature_tenths,
                         humidity_valid, humidity_percent};

endmodule

// File: design/pwsfd_bit_accum.sv
// Symbol stage: slices each symbol to a bit, shifts it into the frame and
// hands the finished frame on at the last symbol. Depends on pwsfd_pkg.
`include "pulse_width_sensor_frame_decoder_defines.svh"

module pwsfd_bit_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pwsfd_pkg::DurW-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          level_first,
  input  logic [pwsfd_pkg::DurW-1:0]    duration_first,
  input  logic [pwsfd_pkg::DurW-1:0]    duration_second,
  input  logic [pwsfd_pkg::CountW-1:0]  frame_symbols,
  input  logic                          last_symbol,
  output logic                          frame_valid,
  input  logic                          frame_ready,
  output pwsfd_pkg::frame_t             frame
);

  logic [pwsfd_pkg::DurW-1:0]   bit_threshold;
  logic [pwsfd_pkg::PosW-1:0]   symbol_position;
  logic [pwsfd_pkg::FrameW-1:0] frame_bits;
  logic [pwsfd_pkg::FrameW-1:0] frame_bits_next;
  logic [pwsfd_pkg::PosW-1:0]   pos_rel;
  logic [pwsfd_pkg::DurW-1:0]   dur;
  logic                         skip;
  logic                         take;
  logic                         in_accept;

  assign in_ready  = !frame_valid || frame_ready;
  assign in_accept = in_valid && in_ready;

  assign dur     = level_first ? duration_first : duration_second;
  // Long captures open with a header symbol; drop it.
  assign skip    = frame_symbols > pwsfd_pkg::MinFrame;
  assign pos_rel = symbol_position - {{(pwsfd_pkg::PosW-1){1'b0}}, skip};
  assign take    = (symbol_position >= {{(pwsfd_pkg::PosW-1){1'b0}}, skip}) &&
                   (pos_rel < pwsfd_pkg::DataBits);

  always_comb begin
    frame_bits_next = frame_bits;
    if (take) begin
      frame_bits_next = {frame_bits[pwsfd_pkg::FrameW-2:0], (dur >= bit_threshold)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold   <= pwsfd_pkg::ThreshReset;
      symbol_position <= '0;
      frame_bits      <= '0;
      frame_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bit_threshold <= cfg_wr_data;
      end
      if (in_accept) begin
        if (last_symbol) begin
          symbol_position <= '0;
          frame_bits      <= '0;
        end else begin
          frame_bits <= frame_bits_next;
          if (symbol_position < pwsfd_pkg::MaxSymbols) begin
            symbol_position <= symbol_position + {{(pwsfd_pkg::PosW-1){1'b0}}, 1'b1};
          end
        end
      end
      if (in_accept && last_symbol) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_symbol) begin
      frame.bits        <= frame_bits_next;
      frame.short_frame <= frame_symbols < pwsfd_pkg::MinFrame;
    end
  end

  `PWSFD_ASSERT_NEXT(a_clear_after_last, in_accept && last_symbol,
                     symbol_position == '0 && frame_bits == '0 && frame_valid)
  `PWSFD_ASSERT_IMPLIES(a_pos_bound, 1'b1, symbol_position <= pwsfd_pkg::MaxSymbols)
  `PWSFD_ASSERT_NEXT(a_frame_hold, frame_valid && !frame_ready,
                     frame_valid && $stable(frame))

endmodule

// File: design/pwsfd_frame_check.sv
// Check stage: verifies the checksum of a finished frame, scales the
// readings and holds the result for the output side. Depends on pwsfd_pkg.
`include "pulse_width_sensor_frame_decoder_defines.svh"

module pwsfd_frame_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  pwsfd_pkg::frame_t             frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pwsfd_pkg::status_t            status,
  output logic [pwsfd_pkg::HumW-1:0]    humidity_percent,
  output logic                          humidity_valid,
  output logic [pwsfd_pkg::TenthsW-1:0] temperature_tenths,
  output logic                          temperature_valid
);

  logic [pwsfd_pkg::ByteW-1:0] hh, hl, th, tl, ck, sum;
  logic [pwsfd_pkg::TempW-1:0] temp;
  pwsfd_pkg::status_t          status_next;
  logic                        hum_ok, temp_ok;

  assign frame_ready = !out_valid || out_ready;

  assign hh  = frame.bits[39:32];
  assign hl  = frame.bits[31:24];
  assign th  = frame.bits[23:16];
  assign tl  = frame.bits[15:8];
  assign ck  = frame.bits[7:0];
  assign sum = hh + hl + th + tl;
  // th * 10 as two shifts.
  assign temp = {1'b0, th, 3'b000} + {3'b000, th, 1'b0} + {4'b0000, tl};

  always_comb begin
    if (frame.short_frame) begin
      status_next = pwsfd_pkg::ST_SHORT;
    end else if (sum != ck) begin
      status_next = pwsfd_pkg::ST_CHECKSUM;
    end else begin
      status_next = pwsfd_pkg::ST_OK;
    end
  end

  assign hum_ok  = (status_next == pwsfd_pkg::ST_OK) && (hh <= pwsfd_pkg::HumMax);
  assign temp_ok = (status_next == pwsfd_pkg::ST_OK) && (temp <= pwsfd_pkg::TempMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      status             <= status_next;
      humidity_valid     <= hum_ok;
      humidity_percent   <= hum_ok ? hh[pwsfd_pkg::HumW-1:0] : '0;
      temperature_valid  <= temp_ok;
      temperature_tenths <= temp_ok ? temp[pwsfd_pkg::TenthsW-1:0] : '0;
    end
  end

  `PWSFD_ASSERT_IMPLIES(a_fail_zeroed, out_valid && status != pwsfd_pkg::ST_OK,
                        !humidity_valid && !temperature_valid &&
                        humidity_percent == '0 && temperature_tenths == '0)
  `PWSFD_ASSERT_IMPLIES(a_range, out_valid,
                        humidity_percent <= 7'd100 && temperature_tenths <= 10'd600)

endmodule
